// ===== design/c2s_pkg.sv =====
// shared types, constants and the arctangent table of the cartesian to spherical core
`default_nettype none

package c2s_pkg;

  localparam int COORD_W         = 16;
  localparam int ANGLE_W         = 16;
  localparam int RHO_W           = 32;
  localparam int FRAC            = RHO_W - COORD_W;
  localparam int CORDIC_W        = RHO_W + 4;
  localparam int ACC_W           = 32;
  localparam int MAX_STEPS       = 32;
  localparam int DEF_ANGLE_STEPS = 16;

  localparam logic [ACC_W-1:0]   ACC_HALF      = 32'h8000_0000;
  localparam logic [ACC_W-1:0]   ACC_QUARTER   = 32'h4000_0000;
  localparam logic [ACC_W-1:0]   ACC_NEG_LIMIT = 32'hC000_0000;
  localparam logic [ACC_W-1:0]   ROUND_BIAS    = 32'h0000_8000;
  localparam logic [ANGLE_W-1:0] THETA_PI      = 16'h8000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x_coord;
    logic signed [COORD_W-1:0] y_coord;
    logic signed [COORD_W-1:0] z_coord;
  } in_t;

  typedef struct packed {
    logic [COORD_W-1:0]        radius;
    logic [ANGLE_W-1:0]        polar_angle;
    logic signed [ANGLE_W-1:0] azimuth;
    logic                      zero_vector;
  } out_t;

  // atan(2^-i) as a fraction of a full turn, 2^32 = one turn
  function automatic logic [ACC_W-1:0] atan_turn(input int unsigned idx);
    logic [ACC_W-1:0] val;
    case (idx)
      0:  val = 32'h20000000;
      1:  val = 32'h12E4051D;
      2:  val = 32'h09FB385B;
      3:  val = 32'h051111D4;
      4:  val = 32'h028B0D43;
      5:  val = 32'h0145D7E1;
      6:  val = 32'h00A2F61E;
      7:  val = 32'h00517C55;
      8:  val = 32'h0028BE53;
      9:  val = 32'h00145F2F;
      10: val = 32'h000A2F98;
      11: val = 32'h000517CC;
      12: val = 32'h00028BE6;
      13: val = 32'h000145F3;
      14: val = 32'h0000A2F9;
      15: val = 32'h0000517C;
      16: val = 32'h000028BE;
      17: val = 32'h0000145F;
      18: val = 32'h00000A2F;
      19: val = 32'h00000517;
      20: val = 32'h0000028B;
      21: val = 32'h00000145;
      22: val = 32'h000000A2;
      23: val = 32'h00000051;
      24: val = 32'h00000028;
      25: val = 32'h00000014;
      26: val = 32'h0000000A;
      27: val = 32'h00000005;
      28: val = 32'h00000002;
      29: val = 32'h00000001;
      default: val = 32'h00000000;
    endcase
    return val;
  endfunction

endpackage

`default_nettype wire

// ===== design/cartesian_to_spherical_core.sv =====
// top level of the cartesian to spherical core
//
// Takes one signed point (x, y, z) per transfer and returns its radius,
// polar angle and azimuth as binary angles (32768 = pi), plus a flag for
// the origin.
// Input: a point is taken at each rising edge with start high and busy low.
// busy never rises, so a point may be sent in every cycle.
// Output: out_valid is high for exactly one cycle with the result in
// out_data; the receiver cannot stall, results leave in input order.
// The delay from the start edge to the result is set by the 32-stage square
// root of the scaled xy length followed by the polar cordic.
// Throughput: one point per clock; every square root and cordic stage is
// its own register stage.
// Reset clears the valid pipeline; points in flight are dropped and no
// stale result is strobed afterwards.
`default_nettype none

module cartesian_to_spherical_core import c2s_pkg::*; #(
  parameter int ANGLE_STEPS = DEF_ANGLE_STEPS
) (
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic start,
  output logic      busy,
  input  wire in_t  in_data,
  output logic      out_valid,
  output out_t      out_data
);

  localparam int VLD_DEPTH = 4 + RHO_W + ANGLE_STEPS;
  localparam int LATENCY   = VLD_DEPTH + 1;
  localparam int RAD_DLY   = RHO_W - COORD_W + ANGLE_STEPS;
  localparam int FLAG_DLY  = RHO_W + ANGLE_STEPS;
  localparam int EXT_W     = CORDIC_W - COORD_W - FRAC;

  logic [VLD_DEPTH-1:0] vld_r;

  logic signed [COORD_W-1:0] x1_r, y1_r, z1_r;
  logic signed [COORD_W-1:0] x2_r, y2_r, z2_r;
  logic [2*COORD_W-1:0]      xsq_r, ysq_r, zsq_r;
  logic signed [COORD_W-1:0] x3_r, y3_r, z3_r;
  logic [2*COORD_W-1:0]      xy2_3_r, zsq3_r;
  logic signed [COORD_W-1:0] x4_r, y4_r, z4_r;
  logic [2*COORD_W-1:0]      xy2_4_r, r2_r;

  logic signed [2*COORD_W-1:0] xsq_nxt, ysq_nxt, zsq_nxt;

  assign busy = 1'b0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else begin
      vld_r <= {vld_r[VLD_DEPTH-2:0], start & ~busy};
    end
  end

  assign xsq_nxt = x1_r * x1_r;
  assign ysq_nxt = y1_r * y1_r;
  assign zsq_nxt = z1_r * z1_r;

  always_ff @(posedge clk) begin
    x1_r    <= in_data.x_coord;
    y1_r    <= in_data.y_coord;
    z1_r    <= in_data.z_coord;
    xsq_r   <= $unsigned(xsq_nxt);
    ysq_r   <= $unsigned(ysq_nxt);
    zsq_r   <= $unsigned(zsq_nxt);
    x2_r    <= x1_r;
    y2_r    <= y1_r;
    z2_r    <= z1_r;
    xy2_3_r <= xsq_r + ysq_r;
    zsq3_r  <= zsq_r;
    x3_r    <= x2_r;
    y3_r    <= y2_r;
    z3_r    <= z2_r;
    r2_r    <= xy2_3_r + zsq3_r;
    xy2_4_r <= xy2_3_r;
    x4_r    <= x3_r;
    y4_r    <= y3_r;
    z4_r    <= z3_r;
  end

  // square roots: radius and the xy length scaled by 2^FRAC
  logic [COORD_W-1:0] radius_q;
  logic [RHO_W-1:0]   rho_q;

  c2s_sqrt #(.W(COORD_W)) u_radius_sqrt (
    .clk    (clk),
    .rad_i  (r2_r),
    .root_o (radius_q)
  );

  c2s_sqrt #(.W(RHO_W)) u_rho_sqrt (
    .clk    (clk),
    .rad_i  ({xy2_4_r, {(2*FRAC){1'b0}}}),
    .root_o (rho_q)
  );

  // azimuth: half-turn pre-rotation when x is negative
  logic signed [CORDIC_W-1:0] xs, ys, phi_a, phi_b;
  logic [ACC_W-1:0]           phi_acc0, phi_acc, phi_acc_d;

  assign xs       = {{EXT_W{x4_r[COORD_W-1]}}, x4_r, {FRAC{1'b0}}};
  assign ys       = {{EXT_W{y4_r[COORD_W-1]}}, y4_r, {FRAC{1'b0}}};
  assign phi_a    = x4_r[COORD_W-1] ? -xs : xs;
  assign phi_b    = x4_r[COORD_W-1] ? -ys : ys;
  assign phi_acc0 = x4_r[COORD_W-1] ? ACC_HALF : '0;

  c2s_cordic #(.STEPS(ANGLE_STEPS)) u_phi_cordic (
    .clk   (clk),
    .a_i   (phi_a),
    .b_i   (phi_b),
    .acc_i (phi_acc0),
    .acc_o (phi_acc)
  );

  // side data waits for the polar cordic
  logic [2:0]                flags4, flags_d;
  logic signed [COORD_W-1:0] z_d;
  logic [COORD_W-1:0]        radius_d;

  assign flags4 = {(x4_r == '0) && (y4_r == '0), z4_r == '0, z4_r[COORD_W-1]};

  c2s_delay #(.W(ACC_W), .DEPTH(RHO_W)) u_phi_dly (
    .clk (clk), .d_i (phi_acc), .d_o (phi_acc_d)
  );

  c2s_delay #(.W(COORD_W), .DEPTH(RAD_DLY)) u_radius_dly (
    .clk (clk), .d_i (radius_q), .d_o (radius_d)
  );

  c2s_delay #(.W(COORD_W), .DEPTH(RHO_W)) u_z_dly (
    .clk (clk), .d_i (z4_r), .d_o (z_d)
  );

  c2s_delay #(.W(3), .DEPTH(FLAG_DLY)) u_flag_dly (
    .clk (clk), .d_i (flags4), .d_o (flags_d)
  );

  // polar angle: quarter-turn pre-rotation when z is negative
  logic signed [CORDIC_W-1:0] zs, rho_s, th_a, th_b;
  logic [ACC_W-1:0]           th_acc0, th_acc;

  assign zs      = {{EXT_W{z_d[COORD_W-1]}}, z_d, {FRAC{1'b0}}};
  assign rho_s   = {{(CORDIC_W-RHO_W){1'b0}}, rho_q};
  assign th_a    = z_d[COORD_W-1] ? rho_s : zs;
  assign th_b    = z_d[COORD_W-1] ? -zs : rho_s;
  assign th_acc0 = z_d[COORD_W-1] ? ACC_QUARTER : '0;

  c2s_cordic #(.STEPS(ANGLE_STEPS)) u_theta_cordic (
    .clk   (clk),
    .a_i   (th_a),
    .b_i   (th_b),
    .acc_i (th_acc0),
    .acc_o (th_acc)
  );

  // clamp, round and special cases
  logic [ACC_W-1:0] th_clamp, th_rnd, phi_rnd;
  logic             xy_zero, z_zero, z_neg;
  out_t             out_nxt;
  out_t             out_data_r;
  logic             out_valid_r;

  assign {xy_zero, z_zero, z_neg} = flags_d;

  always_comb begin
    if (th_acc >= ACC_NEG_LIMIT) begin
      th_clamp = '0;
    end else if (th_acc > ACC_HALF) begin
      th_clamp = ACC_HALF;
    end else begin
      th_clamp = th_acc;
    end
    th_rnd  = th_clamp + ROUND_BIAS;
    phi_rnd = phi_acc_d + ROUND_BIAS;

    out_nxt.radius      = radius_d;
    out_nxt.zero_vector = 1'b0;
    if (xy_zero) begin
      out_nxt.azimuth     = '0;
      out_nxt.polar_angle = z_neg ? THETA_PI : '0;
      out_nxt.zero_vector = z_zero;
    end else begin
      out_nxt.azimuth     = phi_rnd[ACC_W-1 -: ANGLE_W];
      out_nxt.polar_angle = th_rnd[ACC_W-1 -: ANGLE_W];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= vld_r[VLD_DEPTH-1];
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // a result strobe always traces back to a point taken earlier
  a_strobe_source: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, LATENCY))
    else $error("result strobe without a matching input transfer");

  a_origin_zeroed: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.zero_vector |->
      out_data.radius == '0 && out_data.polar_angle == '0 && out_data.azimuth == '0)
    else $error("origin result not cleared");

  a_polar_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.polar_angle <= THETA_PI)
    else $error("polar angle beyond pi");

  a_radius_flag: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> ((out_data.radius == '0) == out_data.zero_vector))
    else $error("zero radius and origin flag disagree");

endmodule

`default_nettype wire

// ===== design/c2s_sqrt.sv =====
// pipelined integer square root, one root bit per stage
`default_nettype none

module c2s_sqrt import c2s_pkg::*; #(
  parameter int W = COORD_W
) (
  input  wire logic           clk,
  input  wire logic [2*W-1:0] rad_i,
  output logic [W-1:0]        root_o
);

  logic [W+1:0]   rem_r  [W];
  logic [W-1:0]   root_r [W];
  logic [2*W-1:0] rad_r  [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    logic [W+1:0]   rem_prev;
    logic [W-1:0]   root_prev;
    logic [2*W-1:0] rad_prev;
    logic [W+3:0]   trial;
    logic [W+3:0]   test;
    logic [W+3:0]   diff;
    logic           ge;

    if (k == 0) begin : g_first
      assign rem_prev  = '0;
      assign root_prev = '0;
      assign rad_prev  = rad_i;
    end else begin : g_next
      assign rem_prev  = rem_r[k-1];
      assign root_prev = root_r[k-1];
      assign rad_prev  = rad_r[k-1];
    end

    assign trial = {rem_prev, rad_prev[2*W-1 -: 2]};
    assign test  = {2'b00, root_prev, 2'b01};
    assign ge    = (trial >= test);
    assign diff  = trial - test;

    always_ff @(posedge clk) begin
      rem_r[k]  <= ge ? diff[W+1:0] : trial[W+1:0];
      root_r[k] <= {root_prev[W-2:0], ge};
      rad_r[k]  <= {rad_prev[2*W-3:0], 2'b00};
    end
  end

  assign root_o = root_r[W-1];

endmodule

`default_nettype wire

// ===== design/c2s_cordic.sv =====
// pipelined vectoring cordic, one micro-rotation per stage, returns the angle
`default_nettype none

module c2s_cordic import c2s_pkg::*; #(
  parameter int STEPS = DEF_ANGLE_STEPS
) (
  input  wire logic                       clk,
  input  wire logic signed [CORDIC_W-1:0] a_i,
  input  wire logic signed [CORDIC_W-1:0] b_i,
  input  wire logic [ACC_W-1:0]           acc_i,
  output logic [ACC_W-1:0]                acc_o
);

  logic signed [CORDIC_W-1:0] a_r   [STEPS];
  logic signed [CORDIC_W-1:0] b_r   [STEPS];
  logic [ACC_W-1:0]           acc_r [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic signed [CORDIC_W-1:0] a_prev;
    logic signed [CORDIC_W-1:0] b_prev;
    logic [ACC_W-1:0]           acc_prev;
    logic signed [CORDIC_W-1:0] da;
    logic signed [CORDIC_W-1:0] db;
    logic                       neg;

    if (k == 0) begin : g_first
      assign a_prev   = a_i;
      assign b_prev   = b_i;
      assign acc_prev = acc_i;
    end else begin : g_next
      assign a_prev   = a_r[k-1];
      assign b_prev   = b_r[k-1];
      assign acc_prev = acc_r[k-1];
    end

    // arithmetic shift rounds toward minus infinity
    assign da  = b_prev >>> k;
    assign db  = a_prev >>> k;
    assign neg = b_prev[CORDIC_W-1];

    always_ff @(posedge clk) begin
      acc_r[k] <= neg ? acc_prev - atan_turn(k) : acc_prev + atan_turn(k);
    end

    if (k < STEPS - 1) begin : g_vec
      always_ff @(posedge clk) begin
        a_r[k] <= neg ? a_prev - da : a_prev + da;
        b_r[k] <= neg ? b_prev + db : b_prev - db;
      end
    end else begin : g_last
      assign a_r[k] = '0;
      assign b_r[k] = '0;
    end
  end

  assign acc_o = acc_r[STEPS-1];

endmodule

`default_nettype wire

// ===== design/c2s_delay.sv =====
// fixed-depth register delay line for data that waits beside the long units
`default_nettype none

module c2s_delay #(
  parameter int W     = 1,
  parameter int DEPTH = 1
) (
  input  wire logic         clk,
  input  wire logic [W-1:0] d_i,
  output logic [W-1:0]      d_o
);

  logic [W-1:0] dly_r [DEPTH];

  always_ff @(posedge clk) begin
    dly_r[0] <= d_i;
    for (int i = 1; i < DEPTH; i++) begin
      dly_r[i] <= dly_r[i-1];
    end
  end

  assign d_o = dly_r[DEPTH-1];

endmodule

`default_nettype wire

// ===== test/testbench.sv =====
// self-checking testbench for the cartesian to spherical core
`default_nettype none

module testbench;
  import c2s_pkg::*;

  localparam int STEPS   = DEF_ANGLE_STEPS;
  localparam int LATENCY = 37 + STEPS;

  logic clk;
  logic rst_n;
  logic start;
  logic busy;
  in_t  in_data;
  logic out_valid;
  out_t out_data;

  out_t pending_points[$];
  int   error_count;
  int   send_idle_pct;

  cartesian_to_spherical_core #(.ANGLE_STEPS(STEPS)) uut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy),
    .in_data(in_data), .out_valid(out_valid), .out_data(out_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

  function automatic longint floor_shift(longint v, int s);
    return v >>> s;
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned n);
    longint unsigned res, bit_v;
    res = 0;
    bit_v = 64'd1 << 62;
    while (bit_v > n) bit_v = bit_v >> 2;
    while (bit_v != 0) begin
      if (n >= res + bit_v) begin
        n = n - (res + bit_v);
        res = (res >> 1) + bit_v;
      end else begin
        res = res >> 1;
      end
      bit_v = bit_v >> 2;
    end
    return res;
  endfunction

  // drives b to zero and accumulates the turned angle
  function automatic logic [ACC_W-1:0] vector_angle(longint a, longint b,
                                                    logic [ACC_W-1:0] acc);
    longint da, db;
    for (int i = 0; i < STEPS && i < MAX_STEPS; i++) begin
      da = floor_shift(b, i);
      db = floor_shift(a, i);
      if (b < 0) begin
        a = a - da;
        b = b + db;
        acc = acc - atan_turn(i);
      end else begin
        a = a + da;
        b = b - db;
        acc = acc + atan_turn(i);
      end
    end
    return acc;
  endfunction

  function automatic logic [ANGLE_W-1:0] round_turn(logic [ACC_W-1:0] acc);
    logic [ACC_W-1:0] t;
    t = acc + ROUND_BIAS;
    return t[31:16];
  endfunction

  function automatic out_t spherical_of(in_t p);
    out_t r;
    longint x, y, z, rho;
    longint unsigned xy2;
    logic [ACC_W-1:0] acc;
    x = p.x_coord;
    y = p.y_coord;
    z = p.z_coord;
    xy2 = x * x + y * y;
    r.radius = COORD_W'(int_sqrt(xy2 + z * z));
    r.zero_vector = 1'b0;
    if (x == 0 && y == 0) begin
      r.azimuth = '0;
      r.zero_vector = (z == 0);
      r.polar_angle = (z < 0) ? THETA_PI : '0;
    end else begin
      x = x <<< FRAC;
      y = y <<< FRAC;
      z = z <<< FRAC;
      rho = int_sqrt(xy2 << (2 * FRAC));
      if (x < 0) acc = vector_angle(-x, -y, ACC_HALF);
      else acc = vector_angle(x, y, '0);
      r.azimuth = round_turn(acc);
      if (z < 0) acc = vector_angle(rho, -z, ACC_QUARTER);
      else acc = vector_angle(z, rho, '0);
      if (acc >= ACC_NEG_LIMIT) acc = '0;
      else if (acc > ACC_HALF) acc = ACC_HALF;
      r.polar_angle = round_turn(acc);
    end
    return r;
  endfunction

  // result checker
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid) begin
      if (pending_points.size() == 0) begin
        $display("%0t unexpected result: expected none, actual %h", $time, out_data);
        error_count++;
      end else begin
        want = pending_points.pop_front();
        if (out_data.radius !== want.radius) begin
          $display("%0t radius: expected %0d, actual %0d", $time, want.radius,
                   out_data.radius);
          error_count++;
        end
        if (out_data.polar_angle !== want.polar_angle) begin
          $display("%0t polar_angle: expected %0d, actual %0d", $time,
                   want.polar_angle, out_data.polar_angle);
          error_count++;
        end
        if (out_data.azimuth !== want.azimuth) begin
          $display("%0t azimuth: expected %0d, actual %0d", $time, want.azimuth,
                   out_data.azimuth);
          error_count++;
        end
        if (out_data.zero_vector !== want.zero_vector) begin
          $display("%0t zero_vector: expected %0b, actual %0b", $time,
                   want.zero_vector, out_data.zero_vector);
          error_count++;
        end
      end
    end
  end

  // start stays high between back to back transfers and drops only while idling
  task automatic send_point(logic [15:0] x, logic [15:0] y, logic [15:0] z);
    in_t p;
    while ($urandom_range(99) < send_idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    p.x_coord = x;
    p.y_coord = y;
    p.z_coord = z;
    start <= 1'b1;
    in_data <= p;
    @(posedge clk);
    while (busy) @(posedge clk);
    pending_points.push_back(spherical_of(p));
  endtask

  task automatic drain_results();
    int guard;
    start <= 1'b0;
    guard = 0;
    while (pending_points.size() != 0 && guard < 100_000) begin
      @(posedge clk);
      guard++;
    end
  endtask

  task automatic test_directed();
    logic [15:0] edge_vals[5];
    edge_vals = '{16'h8000, 16'h7FFF, 16'h0000, 16'h0001, 16'hFFFF};
    send_point(0, 0, 0);
    send_point(0, 0, 16'h7FFF);
    send_point(0, 0, 16'h8000);
    send_point(0, 0, 1);
    send_point(0, 0, 16'hFFFF);
    send_point(16'h8000, 0, 0);
    send_point(16'h8000, 16'hFFFF, 0);
    send_point(16'h8000, 1, 0);
    send_point(0, 16'h7FFF, 0);
    send_point(0, 16'h8000, 16'h8000);
    send_point(16'h8000, 16'h8000, 16'h8000);
    send_point(16'h7FFF, 16'h7FFF, 16'h7FFF);
    foreach (edge_vals[i]) send_point(edge_vals[i], edge_vals[4-i], edge_vals[(i+2)%5]);
    send_point(16'hFFFF, 16'h0001, 16'hFFFF);
    send_point(1, 16'hFFFF, 1);
  endtask

  task automatic test_random(int count);
    logic [15:0] v[3];
    for (int n = 0; n < count; n++) begin
      foreach (v[k]) begin
        case ($urandom_range(5))
          0: v[k] = 16'($urandom_range(3)) - 16'd1;
          1: v[k] = $urandom_range(1) ? 16'h7FFF : 16'h8000;
          2: v[k] = 16'($urandom_range(255)) - 16'd128;
          default: v[k] = 16'($urandom);
        endcase
      end
      if ($urandom_range(19) == 0) begin
        v[0] = '0;
        v[1] = '0;
      end
      send_point(v[0], v[1], v[2]);
    end
  endtask

  task automatic test_pause_until_empty();
    send_point(16'($urandom), 16'($urandom), 16'($urandom));
    send_point(16'($urandom), 16'($urandom), 16'($urandom));
    drain_results();
    send_point(16'($urandom), 16'($urandom), 16'($urandom));
  endtask

  initial begin
    error_count = 0;
    send_idle_pct = 11;
    rst_n = 1'b0;
    start = 1'b0;
    in_data = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random(480);
    test_pause_until_empty();
    send_idle_pct = 65;
    test_random(480);
    send_idle_pct = 0;
    test_random(480);
    drain_results();
    repeat (LATENCY + 10) @(posedge clk);
    if (error_count == 0 && pending_points.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
design/c2s_pkg.sv
design/c2s_sqrt.sv
design/c2s_cordic.sv
design/c2s_delay.sv
design/cartesian_to_spherical_core.sv
test/testbench.sv
